[hw/rtl/bdpc_pkg.sv]
// Package for the button debounce and press classifier.
// Holds event codes, register indexes and the configuration struct.
// No dependencies.
package bdpc_pkg;

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned TIME_W    = 32;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;
    localparam logic [CFG_W-1:0] SHORT_LIMIT_RST = 16'd2500;
    localparam logic [CFG_W-1:0] LONG_LIMIT_RST  = 16'd3000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE    = 2'd0,
        REG_SHORT_LIMIT = 2'd1,
        REG_LONG_LIMIT  = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } t_event;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] short_limit_ms;
        logic [CFG_W-1:0] long_limit_ms;
    } t_cfg;

endpackage

[hw/rtl/bdpc_cfg_regs.sv]
// Configuration register file for the press classifier.
// Depends on bdpc_pkg.
module bdpc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bdpc_pkg::CFG_W-1:0]     i_cfg_wdata,
    output bdpc_pkg::t_cfg                 o_cfg
);
    import bdpc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms    <= DEBOUNCE_RST;
            r_cfg.short_limit_ms <= SHORT_LIMIT_RST;
            r_cfg.long_limit_ms  <= LONG_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_DEBOUNCE:    r_cfg.debounce_ms    <= i_cfg_wdata;
                REG_SHORT_LIMIT: r_cfg.short_limit_ms <= i_cfg_wdata;
                REG_LONG_LIMIT:  r_cfg.long_limit_ms  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/bdpc_core.sv]
// Debounce state and press classification for one poll per cycle while i_fire is high.
// Depends on bdpc_pkg; fed by the input register of the top level.
module bdpc_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bdpc_pkg::t_cfg              i_cfg,
    input  logic                        i_fire,
    input  logic                        i_raw,
    input  logic [bdpc_pkg::TIME_W-1:0] i_now,
    output bdpc_pkg::t_event            o_event
);
    import bdpc_pkg::*;

    logic              r_stable, r_prev, r_held, r_long_done;
    logic [TIME_W-1:0] r_last, r_start;
    logic              n_stable, n_held, n_long_done;
    logic [TIME_W-1:0] n_last, n_start;

    logic              settle, is_short, is_long;
    logic [TIME_W-1:0] since, dur;

    always_comb begin
        n_last   = (i_raw != r_prev) ? i_now : r_last;
        since    = i_now - n_last;
        dur      = i_now - r_start;
        settle   = (since > {{(TIME_W-CFG_W){1'b0}}, i_cfg.debounce_ms}) && (i_raw != r_stable);
        is_short = settle && i_raw && !r_long_done
                   && (dur < {{(TIME_W-CFG_W){1'b0}}, i_cfg.short_limit_ms});
        is_long  = !settle && r_held && !r_long_done
                   && (dur > {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_limit_ms});

        n_stable    = r_stable;
        n_held      = r_held;
        n_long_done = r_long_done;
        n_start     = r_start;
        if (settle) begin
            n_stable = i_raw;
            if (!i_raw) begin
                n_start     = i_now;
                n_held      = 1'b1;
                n_long_done = 1'b0;
            end else begin
                n_held = 1'b0;
            end
        end
        if (is_long) begin
            n_long_done = 1'b1;
        end
    end

    always_comb begin
        if (is_short) begin
            o_event = EV_SHORT;
        end else if (is_long) begin
            o_event = EV_LONG;
        end else begin
            o_event = EV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable    <= 1'b1;
            r_prev      <= 1'b1;
            r_held      <= 1'b0;
            r_long_done <= 1'b0;
            r_last      <= '0;
            r_start     <= '0;
        end else if (i_fire) begin
            r_stable    <= n_stable;
            r_prev      <= i_raw;
            r_held      <= n_held;
            r_long_done <= n_long_done;
            r_last      <= n_last;
            r_start     <= n_start;
        end
    end

    a_held_means_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> !r_stable)
        else $error("held set while stable level is released");

    a_long_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_event == EV_LONG) |=> r_long_done)
        else $error("long event not latched");

    a_short_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_event == EV_SHORT) |=> (r_stable && !r_held))
        else $error("short event without release");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_stable) && $stable(r_long_done) && $stable(r_start)))
        else $error("state moved without a request");

endmodule

[hw/rtl/button_debounce_press_classifier.sv]
// Top level of the button debounce and short/long press classifier.
// Depends on bdpc_pkg, bdpc_cfg_regs and bdpc_core.
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+--------------------------
//  in      | i_in_valid   | o_in_stall   | i_raw_level, i_now_ms
//  out     | o_out_valid  | i_out_stall  | o_press_event
//  cfg     | i_cfg_we     | (none)       | i_cfg_index, i_cfg_wdata
//
// One request per cycle while i_out_stall is low; each passes the input register, then the output register.
// The input register feeds the core, whose state updates as the result loads.
// Synchronous active-low reset clears state and restores default limits.
// A stalled output holds its result and backs up the input register.
module button_debounce_press_classifier (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bdpc_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_raw_level,
    input  logic [bdpc_pkg::TIME_W-1:0]    i_now_ms,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_press_event
);
    import bdpc_pkg::*;

    t_cfg              cfg;
    t_event            core_event;
    logic              r_in_valid, r_raw;
    logic [TIME_W-1:0] r_now;
    logic              r_out_valid;
    t_event            r_out_event;
    logic              advance, fire, accept;

    bdpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bdpc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (fire),
        .i_raw   (r_raw),
        .i_now   (r_now),
        .o_event (core_event)
    );

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_raw <= i_raw_level;
            r_now <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_event <= core_event;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_press_event = r_out_event;

endmodule
